### rtl/life_automaton_torus_step_macros.svh
// Assertion helpers for the life automaton block.
`ifndef LIFE_AUTOMATON_TORUS_STEP_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LATS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LATS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lifets_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lifets_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_EMIT = 2'd2;

    // Field widths of the stream items
    localparam int OP_W       = 2;
    localparam int ROW_IDX_W  = 5;
    localparam int CELLS_W    = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    // B3/S23 rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

`default_nettype wire

### rtl/life_automaton_torus_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Load (op 0): no result items; the block stays ready.
// Emit (op 2): one row item per grid row; no new item is taken until the run ends.
// Step (op 1): one row item per grid row; no new item is taken until the run ends;
//   the rate is set by the single read port of the current store, one row per cycle while the output is not held.
// Output back-pressure freezes the whole read pipeline.
// Reset clears both stores (per-row valid bits) and makes grid A current.
`include "life_automaton_torus_step_macros.svh"

module life_automaton_torus_step
    import lifets_pkg::*;
#(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [4:0] row_index, [36:5] row_cells, [39:37] zero
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] op
    input  wire logic [OP_W-1:0]      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [4:0] out_row, [36:5] out_cells, [39:37] zero
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // last_row
    output logic                      m_axis_tlast
);

    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int SEQ_W  = $clog2(GRID_ROWS + 3);
    // A step reads the last row, every row, then row 0 again
    localparam logic [SEQ_W-1:0]  STEP_TOTAL = SEQ_W'(GRID_ROWS + 2);
    localparam logic [SEQ_W-1:0]  EMIT_TOTAL = SEQ_W'(GRID_ROWS);
    localparam logic [ROW_AW-1:0] LAST_ROW   = ROW_AW'(GRID_ROWS - 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    typedef logic [GRID_COLS-1:0] row_t;

    // ------------------------------------------------------------------
    // Row stores, ping-pong. Rows never written read as dead through the
    // valid bits, which reset clears at once.
    // ------------------------------------------------------------------
    row_t                 mem_a [GRID_ROWS];
    row_t                 mem_b [GRID_ROWS];
    logic [GRID_ROWS-1:0] vld_a_reg;
    logic [GRID_ROWS-1:0] vld_b_reg;
    row_t                 rd_a_reg;
    row_t                 rd_b_reg;

    // Control
    state_t              state_reg;
    logic                step_mode_reg;
    logic                cur_b_reg;
    logic [SEQ_W-1:0]    iss_cnt_reg;
    logic                rd_vld_reg;
    logic                rd_ok_reg;
    logic [SEQ_W-1:0]    rd_seq_reg;

    // Neighbourhood window: the two rows that arrived before the current one
    row_t                win_up_reg;
    row_t                win_mid_reg;

    // Output register
    logic                out_vld_reg;
    logic [ROW_AW-1:0]   out_row_reg;
    row_t                out_cells_reg;
    logic                out_last_reg;

    // Input unpack
    logic [ROW_IDX_W-1:0] in_row_index;
    logic [CELLS_W-1:0]   in_row_cells;
    logic [7:0]           in_idx8;
    logic [63:0]          in_cells64;
    logic [ROW_AW-1:0]    ld_addr;
    row_t                 ld_data;
    logic                 in_accept;
    logic                 load_we;

    // Datapath
    logic                 adv;
    logic [SEQ_W-1:0]     total;
    logic                 issue;
    logic                 rd_en;
    logic [SEQ_W-1:0]     cnt_m1;
    logic [ROW_AW-1:0]    rd_addr;
    logic                 rd_ok_next;
    row_t                 arr_row;
    row_t                 next_row;
    logic [SEQ_W-1:0]     seq_m2;
    logic                 produce;
    logic [ROW_AW-1:0]    prod_row;
    row_t                 prod_cells;
    logic                 step_we;
    logic                 arr_last;
    logic                 done;
    logic                 we_a;
    logic                 we_b;
    logic [ROW_AW-1:0]    wr_addr;
    row_t                 wr_data;
    logic [63:0]          out_cells64;
    logic [7:0]           out_row8;

    assign in_row_index = s_axis_tdata[ROW_IDX_W-1:0];
    assign in_row_cells = s_axis_tdata[ROW_IDX_W+CELLS_W-1:ROW_IDX_W];
    assign in_idx8      = 8'(in_row_index);
    assign in_cells64   = 64'(in_row_cells);
    assign ld_addr      = in_idx8[ROW_AW-1:0];
    // Drop loaded bits beyond the grid's columns
    assign ld_data      = in_cells64[GRID_COLS-1:0];

    // Take new items only when idle: loads then never race the step's reads
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    // Drop loads of rows outside the grid
    assign load_we       = in_accept && (s_axis_tuser == OP_LOAD)
                           && (32'(in_row_index) < GRID_ROWS);

    // Whole pipeline advances together; a held output freezes it
    assign adv   = !out_vld_reg || m_axis_tready;
    assign total = step_mode_reg ? STEP_TOTAL : EMIT_TOTAL;
    assign issue = (state_reg == S_RUN) && (iss_cnt_reg != total);
    assign rd_en = adv && issue;

    // Step read order: last row, rows 0 .. GRID_ROWS-1, row 0 again
    assign cnt_m1 = iss_cnt_reg - SEQ_W'(1);
    always_comb
    begin
        if (!step_mode_reg)
        begin
            rd_addr = iss_cnt_reg[ROW_AW-1:0];
        end
        else if (iss_cnt_reg == '0)
        begin
            rd_addr = LAST_ROW;
        end
        else if (iss_cnt_reg == STEP_TOTAL - SEQ_W'(1))
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = cnt_m1[ROW_AW-1:0];
        end
    end

    assign rd_ok_next = cur_b_reg ? vld_b_reg[rd_addr] : vld_a_reg[rd_addr];

    always_comb
    begin
        if (!rd_ok_reg)
        begin
            arr_row = '0;
        end
        else if (cur_b_reg)
        begin
            arr_row = rd_b_reg;
        end
        else
        begin
            arr_row = rd_a_reg;
        end
    end

    // One lane per column: count the eight neighbours with wrap-around
    for (genvar c = 0; c < GRID_COLS; c++)
    begin : g_lane
        localparam int L = (c == 0) ? GRID_COLS - 1 : c - 1;
        localparam int R = (c == GRID_COLS - 1) ? 0 : c + 1;
        logic [3:0] n;
        assign n = 4'(win_up_reg[L]) + 4'(win_up_reg[c]) + 4'(win_up_reg[R])
                 + 4'(win_mid_reg[L]) + 4'(win_mid_reg[R])
                 + 4'(arr_row[L]) + 4'(arr_row[c]) + 4'(arr_row[R]);
        assign next_row[c] = (n == BIRTH_COUNT) || (win_mid_reg[c] && (n == SURVIVE_COUNT));
    end

    // A step yields row k-2 when arrival k lands, an emit yields row k
    assign seq_m2     = rd_seq_reg - SEQ_W'(2);
    assign produce    = adv && rd_vld_reg && (!step_mode_reg || (rd_seq_reg >= SEQ_W'(2)));
    assign prod_row   = step_mode_reg ? seq_m2[ROW_AW-1:0] : rd_seq_reg[ROW_AW-1:0];
    assign prod_cells = step_mode_reg ? next_row : arr_row;
    assign step_we    = produce && step_mode_reg;
    assign arr_last   = (rd_seq_reg == total - SEQ_W'(1));
    assign done       = adv && rd_vld_reg && arr_last;

    // Write ports: a load hits the current store, a step the other one
    assign we_a    = (load_we && !cur_b_reg) || (step_we && cur_b_reg);
    assign we_b    = (load_we && cur_b_reg) || (step_we && !cur_b_reg);
    assign wr_addr = load_we ? ld_addr : prod_row;
    assign wr_data = load_we ? ld_data : prod_cells;

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (rd_en && !cur_b_reg)
        begin
            rd_a_reg <= mem_a[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        if (rd_en && cur_b_reg)
        begin
            rd_b_reg <= mem_b[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
        end
        else
        begin
            if (we_a)
            begin
                vld_a_reg[wr_addr] <= 1'b1;
            end
            if (we_b)
            begin
                vld_b_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_mode_reg <= 1'b0;
            cur_b_reg     <= 1'b0;
            iss_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            rd_ok_reg     <= 1'b0;
            rd_seq_reg    <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (s_axis_tuser inside {OP_STEP, OP_EMIT}))
                    begin
                        state_reg     <= S_RUN;
                        step_mode_reg <= (s_axis_tuser == OP_STEP);
                        iss_cnt_reg   <= '0;
                    end
                end
                S_RUN:
                begin
                    if (done)
                    begin
                        state_reg <= S_IDLE;
                        // Swap stores once the new generation is fully written
                        if (step_mode_reg)
                        begin
                            cur_b_reg <= !cur_b_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (adv)
            begin
                rd_vld_reg <= issue;
                if (issue)
                begin
                    iss_cnt_reg <= iss_cnt_reg + SEQ_W'(1);
                    rd_ok_reg   <= rd_ok_next;
                    rd_seq_reg  <= iss_cnt_reg;
                end
                out_vld_reg <= produce;
            end
        end
    end

    // Payload registers: window and output data
    always_ff @(posedge clk)
    begin
        if (adv && rd_vld_reg)
        begin
            win_up_reg  <= win_mid_reg;
            win_mid_reg <= arr_row;
        end
        if (produce)
        begin
            out_row_reg   <= prod_row;
            out_cells_reg <= prod_cells;
            out_last_reg  <= (prod_row == LAST_ROW);
        end
    end

    // Output pack: keep the low 5 row bits and the low 32 cell bits
    assign out_cells64   = 64'(out_cells_reg);
    assign out_row8      = 8'(out_row_reg);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_cells64[CELLS_W-1:0], out_row8[ROW_IDX_W-1:0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LATS_ASSERT_NOW(a_rd_only_busy, clk, rst_n, rd_vld_reg, state_reg == S_RUN,
        "read data in flight while idle")
    `LATS_ASSERT_NEXT(a_done_idle, clk, rst_n, done, (state_reg == S_IDLE) && !rd_vld_reg,
        "sequencer did not stop after the final row")
    `LATS_ASSERT_NEXT(a_step_swaps, clk, rst_n, done && step_mode_reg,
        cur_b_reg != $past(cur_b_reg), "step finished without swapping stores")
    `LATS_ASSERT_NOW(a_no_write_clash, clk, rst_n, step_we, !load_we,
        "load and step wrote a store in the same cycle")

endmodule

`default_nettype wire

### tb/sv/tb_life_automaton_torus_step.sv
`timescale 1ns / 1ps

module tb_life_automaton_torus_step;
    import lifets_pkg::*;

    localparam int GRID_ROWS    = 32;
    localparam int GRID_COLS    = 32;
    localparam int RANDOM_ITEMS = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [4:0]  row;
        logic [31:0] cells;
        logic        is_last;
    } row_item_t;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  idx;
        logic [31:0] cells;
        bit          typed;
        logic [31:0] typed_cells;
    } stim_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0]      s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    // Predicted grid: two stores used ping-pong, grid_sel picks the current one
    logic [31:0] grid_store [2][GRID_ROWS];
    bit          grid_sel;
    row_item_t   pending_rows[$];
    stim_t       directed[$];

    int fail_count   = 0;
    int random_items = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    bit hold_done    = 1'b0;

    life_automaton_torus_step #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // B3/S23 on one row, neighbours wrapping at both column edges
    function automatic logic [31:0] life_next_row(logic [31:0] up, logic [31:0] here,
                                                  logic [31:0] down);
        logic [31:0] nxt;
        int n;
        int l;
        int r;
        nxt = '0;
        for (int c = 0; c < GRID_COLS; c++)
        begin
            l = (c + GRID_COLS - 1) % GRID_COLS;
            r = (c + 1) % GRID_COLS;
            n = int'(up[l]) + int'(up[c]) + int'(up[r]) + int'(here[l]) + int'(here[r])
              + int'(down[l]) + int'(down[c]) + int'(down[r]);
            if (n == int'(BIRTH_COUNT) || (here[c] && n == int'(SURVIVE_COUNT)))
                nxt[c] = 1'b1;
        end
        return nxt;
    endfunction

    function automatic logic [31:0] random_row_cells();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom() & $urandom() & $urandom();
            1: v = $urandom() & $urandom();
            2: v = $urandom();
            3: v = $urandom() | $urandom();
            default: v = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        endcase
        return v;
    endfunction

    // Advance the predicted grid and queue the row items this item causes
    task automatic predict_item(stim_t s);
        logic [31:0] fresh [GRID_ROWS];
        row_item_t   ri;
        case (s.op)
            OP_LOAD:
                grid_store[grid_sel][s.idx] = s.cells;
            OP_STEP:
            begin
                for (int r = 0; r < GRID_ROWS; r++)
                    fresh[r] = life_next_row(grid_store[grid_sel][(r + GRID_ROWS - 1) % GRID_ROWS],
                                             grid_store[grid_sel][r],
                                             grid_store[grid_sel][(r + 1) % GRID_ROWS]);
                grid_sel = grid_sel ^ 1'b1;
                for (int r = 0; r < GRID_ROWS; r++)
                    grid_store[grid_sel][r] = fresh[r];
            end
            default: ;
        endcase
        if (s.op == OP_STEP || s.op == OP_EMIT)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                ri.row     = 5'(r);
                ri.cells   = s.typed ? s.typed_cells : grid_store[grid_sel][r];
                ri.is_last = (r == GRID_ROWS - 1);
                pending_rows.push_back(ri);
            end
        end
    endtask

    // Entered and left at a rising edge; drives at falling edges only
    task automatic send_item(stim_t s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.op;
        s_axis_tdata  <= {3'b000, s.cells, s.idx};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        predict_item(s);
    endtask

    task automatic add_row(logic [1:0] op, logic [4:0] idx, logic [31:0] cells,
                           bit typed = 1'b0, logic [31:0] typed_cells = '0);
        stim_t s;
        s.op          = op;
        s.idx         = idx;
        s.cells       = cells;
        s.typed       = typed;
        s.typed_cells = typed_cells;
        directed.push_back(s);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare every row item taken by the receiver with the oldest expectation
    always @(posedge clk)
    begin
        row_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected row item, expected none, actual %h", $time,
                         m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_rows.pop_front();
                check_field("out_row", 32'(want.row), 32'(m_axis_tdata[4:0]));
                check_field("out_cells", want.cells, m_axis_tdata[36:5]);
                check_field("last_row", 32'(want.is_last), 32'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Receiver: switches between random ready patterns, plus one long hold-off mid-run
    initial
    begin
        int mode;
        int cyc;
        mode = 0;
        cyc  = 0;
        wait (rst_n);
        forever
        begin
            if (!hold_done && random_items >= 70)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
                hold_done = 1'b1;
            end
            else
            begin
                @(negedge clk);
                if (cyc % 50 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= (cyc % 3 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
                cyc++;
            end
        end
    end

    initial
    begin
        stim_t s;
        int k;
        int pick;
        for (int b = 0; b < 2; b++)
            for (int r = 0; r < GRID_ROWS; r++)
                grid_store[b][r] = '0;
        grid_sel = 1'b0;

        // Empty grid after reset, and a step of it, stay empty
        add_row(OP_EMIT, 5'd0, 32'h0000_0000, 1'b1, 32'h0000_0000);
        add_row(OP_STEP, 5'd31, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
        // Unused op changes nothing
        add_row(OP_UNUSED, 5'd0, 32'hFFFF_FFFF);
        add_row(OP_EMIT, 5'd31, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
        // Full first and last rows: neighbours meet across the row wrap
        add_row(OP_LOAD, 5'd0, 32'hFFFF_FFFF);
        add_row(OP_LOAD, 5'd31, 32'hFFFF_FFFF);
        add_row(OP_EMIT, 5'd0, 32'h0000_0000);
        add_row(OP_STEP, 5'd0, 32'h0000_0000);
        add_row(OP_STEP, 5'd0, 32'h0000_0000);
        // Blinker across the column wrap
        add_row(OP_LOAD, 5'd5, 32'h8000_0003);
        add_row(OP_STEP, 5'd0, 32'h0000_0000);
        add_row(OP_STEP, 5'd0, 32'h0000_0000);
        // Vertical blinker across the row wrap
        add_row(OP_LOAD, 5'd31, 32'h0001_0000);
        add_row(OP_LOAD, 5'd0, 32'h0001_0000);
        add_row(OP_LOAD, 5'd1, 32'h0001_0000);
        add_row(OP_STEP, 5'd0, 32'h0000_0000);
        // Glider on the corner
        add_row(OP_LOAD, 5'd29, 32'h0000_0001);
        add_row(OP_LOAD, 5'd30, 32'h0000_0002);
        add_row(OP_LOAD, 5'd31, 32'h8000_0003);
        add_row(OP_STEP, 5'd0, 32'h0000_0000);
        add_row(OP_STEP, 5'd0, 32'h0000_0000);
        add_row(OP_EMIT, 5'd0, 32'h0000_0000);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i]);

        // Random part: mostly loads followed by steps, with some emits and noise
        s.typed       = 1'b0;
        s.typed_cells = '0;
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
            begin
                k = $urandom_range(1, 6);
                repeat (k)
                begin
                    s.op    = OP_LOAD;
                    s.idx   = 5'($urandom_range(0, GRID_ROWS - 1));
                    s.cells = random_row_cells();
                    send_item(s);
                    random_items++;
                end
                k = $urandom_range(1, 3);
                repeat (k)
                begin
                    s.op    = ($urandom_range(0, 3) == 0) ? OP_EMIT : OP_STEP;
                    s.idx   = 5'($urandom());
                    s.cells = $urandom();
                    send_item(s);
                    random_items++;
                end
            end
            else if (pick == 7)
            begin
                s.op    = OP_EMIT;
                s.idx   = 5'($urandom());
                s.cells = $urandom();
                send_item(s);
                random_items++;
            end
            else
            begin
                // Noise: unused op between stray loads
                s.op    = OP_UNUSED;
                s.idx   = 5'($urandom());
                s.cells = $urandom();
                send_item(s);
                s.op    = OP_LOAD;
                s.idx   = 5'($urandom());
                s.cells = random_row_cells();
                send_item(s);
                random_items++;
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
